[rtl/gsd_pkg.sv]
package gsd_pkg;

	localparam int unsigned ANGLE_W   = 16;
	localparam int unsigned TOL_W     = 15;
	localparam int unsigned LIMIT_W   = 8;
	localparam int unsigned TARGETS   = 4;
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned DIFF_W    = ANGLE_W + 1;

	localparam logic [2:0] REG_TARGET_0    = 3'd0;
	localparam logic [2:0] REG_TARGET_1    = 3'd1;
	localparam logic [2:0] REG_TARGET_2    = 3'd2;
	localparam logic [2:0] REG_TARGET_3    = 3'd3;
	localparam logic [2:0] REG_GOAL_TOL    = 3'd4;
	localparam logic [2:0] REG_STILL_TOL   = 3'd5;
	localparam logic [2:0] REG_STILL_LIMIT = 3'd6;

	localparam logic FUNC_START  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		OUT_RUNNING   = 3'd0,
		OUT_AT_TARGET = 3'd1,
		OUT_SETTLED   = 3'd2,
		OUT_BLOCKED   = 3'd3,
		OUT_INVALID   = 3'd4,
		OUT_IDLE      = 3'd5
	} gsd_outcome_t;

	typedef struct packed {
		logic [TARGETS-1:0][ANGLE_W-1:0] target;
		logic [TOL_W-1:0]                goal_tol;
		logic [TOL_W-1:0]                still_tol;
		logic [LIMIT_W-1:0]              still_limit;
	} gsd_cfg_t;

	typedef struct packed {
		logic start;
		logic count;
	} gsd_joint_ctl_t;

	typedef struct packed {
		logic at_goal;
		logic still_ok;
		logic moved;
	} gsd_joint_sts_t;

	function automatic logic [DIFF_W-1:0] abs_diff(logic [ANGLE_W-1:0] a,
			logic [ANGLE_W-1:0] b);
		logic signed [DIFF_W-1:0] d;
		d = $signed({a[ANGLE_W-1], a}) - $signed({b[ANGLE_W-1], b});
		return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
	endfunction

endpackage

[rtl/gsd_cfg.sv]
module gsd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gsd_pkg::ADDR_W-1:0]     paddr,
	input  logic [gsd_pkg::DATA_W-1:0]     pwdata,
	output logic [gsd_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	output gsd_pkg::gsd_cfg_t              cfg
);

	gsd_pkg::gsd_cfg_t cfg_q;
	logic [2:0]        idx;
	logic              wr;

	assign idx    = paddr[gsd_pkg::ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target      <= '0;
			cfg_q.goal_tol    <= '0;
			cfg_q.still_tol   <= '0;
			cfg_q.still_limit <= gsd_pkg::LIMIT_W'(1);
		end else if (wr) begin
			case (idx)
				gsd_pkg::REG_TARGET_0:    cfg_q.target[0]   <= pwdata[gsd_pkg::ANGLE_W-1:0];
				gsd_pkg::REG_TARGET_1:    cfg_q.target[1]   <= pwdata[gsd_pkg::ANGLE_W-1:0];
				gsd_pkg::REG_TARGET_2:    cfg_q.target[2]   <= pwdata[gsd_pkg::ANGLE_W-1:0];
				gsd_pkg::REG_TARGET_3:    cfg_q.target[3]   <= pwdata[gsd_pkg::ANGLE_W-1:0];
				gsd_pkg::REG_GOAL_TOL:    cfg_q.goal_tol    <= pwdata[gsd_pkg::TOL_W-1:0];
				gsd_pkg::REG_STILL_TOL:   cfg_q.still_tol   <= pwdata[gsd_pkg::TOL_W-1:0];
				gsd_pkg::REG_STILL_LIMIT: cfg_q.still_limit <= pwdata[gsd_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			gsd_pkg::REG_TARGET_0:    prdata = {{16{cfg_q.target[0][15]}}, cfg_q.target[0]};
			gsd_pkg::REG_TARGET_1:    prdata = {{16{cfg_q.target[1][15]}}, cfg_q.target[1]};
			gsd_pkg::REG_TARGET_2:    prdata = {{16{cfg_q.target[2][15]}}, cfg_q.target[2]};
			gsd_pkg::REG_TARGET_3:    prdata = {{16{cfg_q.target[3][15]}}, cfg_q.target[3]};
			gsd_pkg::REG_GOAL_TOL:    prdata = {17'd0, cfg_q.goal_tol};
			gsd_pkg::REG_STILL_TOL:   prdata = {17'd0, cfg_q.still_tol};
			gsd_pkg::REG_STILL_LIMIT: prdata = {24'd0, cfg_q.still_limit};
			default:                  prdata = '0;
		endcase
	end

endmodule

[rtl/gsd_joint.sv]
module gsd_joint #(
	parameter int unsigned COUNT_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gsd_pkg::gsd_joint_ctl_t         ctl,
	input  logic [gsd_pkg::ANGLE_W-1:0]     angle,
	input  logic [gsd_pkg::ANGLE_W-1:0]     target,
	input  logic [gsd_pkg::TOL_W-1:0]       goal_tol,
	input  logic [gsd_pkg::TOL_W-1:0]       still_tol,
	input  logic [gsd_pkg::LIMIT_W-1:0]     still_limit,
	output gsd_pkg::gsd_joint_sts_t         sts
);

	localparam int unsigned CMP_W = (COUNT_BITS > gsd_pkg::LIMIT_W) ? COUNT_BITS
		: gsd_pkg::LIMIT_W;

	logic [gsd_pkg::ANGLE_W-1:0] prev_q;
	logic [COUNT_BITS-1:0]       still_cnt_q;
	logic [COUNT_BITS-1:0]       moved_cnt_q;
	logic [COUNT_BITS-1:0]       still_inc;
	logic [COUNT_BITS-1:0]       moved_inc;
	logic [gsd_pkg::DIFF_W-1:0]  goal_diff;
	logic [gsd_pkg::DIFF_W-1:0]  move_diff;
	logic                        is_still;

	assign goal_diff = gsd_pkg::abs_diff(angle, target);
	assign move_diff = gsd_pkg::abs_diff(angle, prev_q);
	assign is_still  = move_diff < gsd_pkg::DIFF_W'(still_tol);
	assign still_inc = (&still_cnt_q) ? still_cnt_q : still_cnt_q + 1'b1;
	assign moved_inc = (&moved_cnt_q) ? moved_cnt_q : moved_cnt_q + 1'b1;

	// Status as seen after this sample's count update
	assign sts.at_goal  = goal_diff <= gsd_pkg::DIFF_W'(goal_tol);
	assign sts.still_ok = is_still ? (CMP_W'(still_inc) >= CMP_W'(still_limit))
		: (still_limit == '0);
	assign sts.moved    = !is_still;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			still_cnt_q <= '0;
			moved_cnt_q <= '0;
		end else if (ctl.start) begin
			prev_q      <= angle;
			still_cnt_q <= '0;
			moved_cnt_q <= '0;
		end else if (ctl.count) begin
			prev_q <= angle;
			if (is_still) begin
				still_cnt_q <= still_inc;
				moved_cnt_q <= '0;
			end else begin
				still_cnt_q <= '0;
				moved_cnt_q <= moved_inc;
			end
		end
	end

endmodule

[rtl/gripper_settle_detector_top.sv]
// Channel  Direction  Handshake            Word
// in       input      in_valid/in_ready    func, sample_valid, angle_0..angle_3
// out      output     out_valid/out_ready  outcome, finished
// apb      input      psel/penable/pready  paddr, pwdata, prdata
//
// Two register stages: input register, then result register.
// One word per cycle sustained while out_ready is high; joint state is updated as a word leaves stage 1.
// arst_n clears valid flags, active flag, counters and config registers; data registers are not reset.
// A stalled result holds stage 1; in_ready drops only when both stages are full.
module gripper_settle_detector_top #(
	parameter int unsigned JOINTS     = 4,
	parameter int unsigned COUNT_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic                        sample_valid,
	input  logic signed [15:0]          angle_0,
	input  logic signed [15:0]          angle_1,
	input  logic signed [15:0]          angle_2,
	input  logic signed [15:0]          angle_3,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  outcome,
	output logic                        finished,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gsd_pkg::ADDR_W-1:0]  paddr,
	input  logic [gsd_pkg::DATA_W-1:0]  pwdata,
	output logic [gsd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	gsd_pkg::gsd_cfg_t                         cfg;
	gsd_pkg::gsd_joint_ctl_t                   jctl;
	gsd_pkg::gsd_joint_sts_t [JOINTS-1:0]      jsts;
	logic [gsd_pkg::TARGETS-1:0][gsd_pkg::ANGLE_W-1:0] angle_in;

	logic                                      valid_s1;
	logic                                      func_s1;
	logic                                      sv_s1;
	logic [JOINTS-1:0][gsd_pkg::ANGLE_W-1:0]   angle_s1;

	logic                                      res_valid_q;
	gsd_pkg::gsd_outcome_t                     outcome_q;
	logic                                      finished_q;
	logic                                      active_q;
	logic [COUNT_BITS-1:0]                     never_moved_q;

	localparam int unsigned CMP_W = (COUNT_BITS > gsd_pkg::LIMIT_W) ? COUNT_BITS
		: gsd_pkg::LIMIT_W;

	logic                                      adv;
	logic                                      take;
	logic [JOINTS-1:0]                         at_goal_v;
	logic [JOINTS-1:0]                         still_v;
	logic [JOINTS-1:0]                         moved_v;
	logic                                      at_goal_all;
	logic                                      all_still;
	logic                                      one_moved;
	logic [COUNT_BITS-1:0]                     nm_inc;
	gsd_pkg::gsd_outcome_t                     outcome_d;
	logic                                      fin_d;
	logic                                      active_d;
	logic [COUNT_BITS-1:0]                     nm_d;

	assign angle_in = {angle_3, angle_2, angle_1, angle_0};

	assign adv      = !res_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign take     = valid_s1 && adv;

	gsd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	for (genvar j = 0; j < JOINTS; j++) begin : g_joint
		gsd_joint #(
			.COUNT_BITS (COUNT_BITS)
		) u_joint (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (jctl),
			.angle       (angle_s1[j]),
			.target      (cfg.target[j]),
			.goal_tol    (cfg.goal_tol),
			.still_tol   (cfg.still_tol),
			.still_limit (cfg.still_limit),
			.sts         (jsts[j])
		);
		assign at_goal_v[j] = jsts[j].at_goal;
		assign still_v[j]   = jsts[j].still_ok;
		assign moved_v[j]   = jsts[j].moved;
	end

	assign at_goal_all = &at_goal_v;
	assign all_still   = &still_v;
	assign one_moved   = |moved_v;
	assign nm_inc      = (&never_moved_q) ? never_moved_q : never_moved_q + 1'b1;

	assign jctl.start = take && (func_s1 == gsd_pkg::FUNC_START) && sv_s1;
	assign jctl.count = take && (func_s1 == gsd_pkg::FUNC_SAMPLE) && active_q && sv_s1
		&& !at_goal_all;

	always_comb begin
		outcome_d = gsd_pkg::OUT_RUNNING;
		fin_d     = 1'b0;
		active_d  = active_q;
		nm_d      = never_moved_q;
		if (func_s1 == gsd_pkg::FUNC_START) begin
			if (!sv_s1) begin
				outcome_d = gsd_pkg::OUT_INVALID;
			end else begin
				active_d = 1'b1;
				nm_d     = '0;
			end
		end else if (!active_q) begin
			outcome_d = gsd_pkg::OUT_IDLE;
		end else if (!sv_s1) begin
			outcome_d = gsd_pkg::OUT_INVALID;
			fin_d     = 1'b1;
			active_d  = 1'b0;
		end else if (at_goal_all) begin
			outcome_d = gsd_pkg::OUT_AT_TARGET;
			fin_d     = 1'b1;
			active_d  = 1'b0;
		end else if (all_still) begin
			if (one_moved) begin
				outcome_d = gsd_pkg::OUT_SETTLED;
				fin_d     = 1'b1;
				active_d  = 1'b0;
			end else begin
				nm_d = nm_inc;
				if (CMP_W'(nm_inc) >= CMP_W'(cfg.still_limit)) begin
					outcome_d = gsd_pkg::OUT_BLOCKED;
					fin_d     = 1'b1;
					active_d  = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			res_valid_q   <= 1'b0;
			active_q      <= 1'b0;
			never_moved_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				res_valid_q <= valid_s1;
			end
			if (take) begin
				active_q      <= active_d;
				never_moved_q <= nm_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			sv_s1   <= sample_valid;
			for (int j = 0; j < JOINTS; j++) begin
				angle_s1[j] <= angle_in[j];
			end
		end
		if (take) begin
			outcome_q  <= outcome_d;
			finished_q <= fin_d;
		end
	end

	assign out_valid = res_valid_q;
	assign outcome   = outcome_q;
	assign finished  = finished_q;

	a_fin_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take && fin_d |=> !active_q)
		else $error("block still active after a finishing word");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && res_valid_q && !out_ready)
		else $error("input stalled with a free stage");

	a_settled_limit: assert property (@(posedge clk) disable iff (!arst_n)
		take && outcome_d == gsd_pkg::OUT_SETTLED |-> cfg.still_limit == '0)
		else $error("settled outcome with nonzero still limit");

	a_fin_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> outcome_q != gsd_pkg::OUT_RUNNING
			&& outcome_q != gsd_pkg::OUT_IDLE)
		else $error("finished word with running or idle outcome");

endmodule
